### src/guwg_pkg.sv
// Shared types and constants of the weighted gray grid upscaler.
package guwg_pkg;

   localparam int GRID_MAX    = 64;
   localparam int CELL_BITS   = $clog2(GRID_MAX);
   localparam int VALUE_BITS  = 16;
   localparam int FRAC_BITS   = 14;
   localparam int PIX_BITS    = 14;
   localparam int RECIP_SHIFT = 14;
   localparam int RECIP_BITS  = RECIP_SHIFT + 1;
   localparam int BANK_AW     = 2 * (CELL_BITS - 1);
   localparam int BANK_DEPTH  = 1 << BANK_AW;
   localparam int DIV_STAGES  = 8;
   localparam int NUM_BITS    = 56;
   localparam int LIM_BITS    = 48;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic REG_GRID_SIZE = 1'b0;
   localparam logic REG_SCALE     = 1'b1;

   localparam logic [6:0] GRID_SIZE_RESET = 7'd40;
   localparam logic [7:0] SCALE_RESET     = 8'd10;

   typedef struct packed {
      logic [PIX_BITS-1:0] px;
      logic [PIX_BITS-1:0] py;
      logic                ok;
      logic                neg;
      logic                sat;
   } meta_type;

endpackage

### src/grid_upscale_weighted_gray.sv
// One item per cycle sustained while the result side does not stall and no grid clear runs.
// Coordinates split by a reciprocal multiply with one correction step; the four
// neighbors come from four parity banks read in the same cycle; the weighted mean
// goes through an eight-stage restoring divider, one quotient bit per stage.
// Reset: synchronous; after reset the grid banks are cleared entry by entry, during
// which no input is taken. Writes produce no result.
module grid_upscale_weighted_gray (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,   // cell_x, cell_y, cell_value, pixel_x, pixel_y
   input  logic [0:0]   req_tuser,   // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // out_x, out_y, gray, zero fill
   output logic [0:0]   rsp_tuser,   // in_range
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import guwg_pkg::*;

   // reciprocal table
   logic [RECIP_BITS-1:0] recip_tbl [256];
   for (genvar g = 0; g < 256; g++) begin : g_recip
      localparam int RV = (g == 0) ? 0 : (1 << RECIP_SHIFT) / g;
      assign recip_tbl[g] = RV[RECIP_BITS-1:0];
   end

   // configuration
   logic [6:0]            grid_size_ff;
   logic [7:0]            scale_ff;
   logic [RECIP_BITS-1:0] recip_ff;
   logic                  csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         REG_GRID_SIZE: csr_prdata = {25'd0, grid_size_ff};
         REG_SCALE:     csr_prdata = {24'd0, scale_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_SIZE_RESET;
         scale_ff     <= SCALE_RESET;
         recip_ff     <= recip_tbl[SCALE_RESET];
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_GRID_SIZE: grid_size_ff <= csr_pwdata[6:0];
            REG_SCALE: begin
               scale_ff <= csr_pwdata[7:0];
               recip_ff <= recip_tbl[csr_pwdata[7:0]];
            end
            default: ;
         endcase
      end
   end

   // clearing pass and flow control
   logic               clr_busy_ff;
   logic [BANK_AW-1:0] clr_cnt_ff;
   logic               en;
   logic               skid_v_ff;
   logic               req_take;

   assign en         = !skid_v_ff;
   assign req_tready = en && !clr_busy_ff;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (&clr_cnt_ff) clr_busy_ff <= 1'b0;
      end
   end

   // input unpack
   logic [CELL_BITS-1:0]  in_cx, in_cy;
   logic [VALUE_BITS-1:0] in_val;
   logic [PIX_BITS-1:0]   in_px, in_py;
   logic [6:0]            n_use;
   logic [14:0]           lim_pix;
   logic                  in_ok;

   assign in_cx   = req_tdata[5:0];
   assign in_cy   = req_tdata[11:6];
   assign in_val  = req_tdata[27:12];
   assign in_px   = req_tdata[41:28];
   assign in_py   = req_tdata[55:42];
   assign n_use   = (grid_size_ff > 7'(GRID_MAX)) ? 7'(GRID_MAX) : grid_size_ff;
   assign lim_pix = n_use * scale_ff;
   assign in_ok   = (scale_ff != 8'd0) && ({6'd0, scale_ff} <= in_px)
                    && ({6'd0, scale_ff} <= in_py)
                    && ({1'b0, in_px} < lim_pix) && ({1'b0, in_py} < lim_pix);

   // stage A: reciprocal products
   logic                  a_v_ff, a_q_ff;
   meta_type              a_meta_ff;
   logic [CELL_BITS-1:0]  a_cx_ff, a_cy_ff;
   logic [VALUE_BITS-1:0] a_val_ff;
   logic [28:0]           a_prx_ff, a_pry_ff;
   // stage B: quotient estimate times scale
   logic                  b_v_ff, b_q_ff;
   meta_type              b_meta_ff;
   logic [CELL_BITS-1:0]  b_cx_ff, b_cy_ff;
   logic [VALUE_BITS-1:0] b_val_ff;
   logic [PIX_BITS-1:0]   b_qx_ff, b_qy_ff;
   logic [21:0]           b_qsx_ff, b_qsy_ff;
   // stage C: corrected cell and offset
   logic                  c_v_ff, c_q_ff;
   meta_type              c_meta_ff;
   logic [CELL_BITS-1:0]  c_cx_ff, c_cy_ff;
   logic [VALUE_BITS-1:0] c_val_ff;
   logic [CELL_BITS-1:0]  c_ci_ff, c_cj_ff;
   logic [7:0]            c_im_ff, c_jm_ff;

   logic [PIX_BITS-1:0] b_qx_in, b_qy_in;
   logic [8:0]          rx, ry;
   logic                fix_x, fix_y;

   assign b_qx_in = a_prx_ff[27:14];
   assign b_qy_in = a_pry_ff[27:14];
   assign rx      = 9'(b_meta_ff.px - b_qsx_ff[PIX_BITS-1:0]);
   assign ry      = 9'(b_meta_ff.py - b_qsy_ff[PIX_BITS-1:0]);
   assign fix_x   = rx >= {1'b0, scale_ff};
   assign fix_y   = ry >= {1'b0, scale_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         a_q_ff    <= req_tuser[0] == CMD_QUERY;
         a_meta_ff <= '{px: in_px, py: in_py, ok: in_ok, neg: 1'b0, sat: 1'b0};
         a_cx_ff   <= in_cx;
         a_cy_ff   <= in_cy;
         a_val_ff  <= in_val;
         a_prx_ff  <= in_px * recip_ff;
         a_pry_ff  <= in_py * recip_ff;

         b_q_ff    <= a_q_ff;
         b_meta_ff <= a_meta_ff;
         b_cx_ff   <= a_cx_ff;
         b_cy_ff   <= a_cy_ff;
         b_val_ff  <= a_val_ff;
         b_qx_ff   <= b_qx_in;
         b_qy_ff   <= b_qy_in;
         b_qsx_ff  <= b_qx_in * scale_ff;
         b_qsy_ff  <= b_qy_in * scale_ff;

         c_q_ff    <= b_q_ff;
         c_meta_ff <= b_meta_ff;
         c_cx_ff   <= b_cx_ff;
         c_cy_ff   <= b_cy_ff;
         c_val_ff  <= b_val_ff;
         c_ci_ff   <= fix_x ? CELL_BITS'(b_qx_ff + 1'b1) : b_qx_ff[CELL_BITS-1:0];
         c_cj_ff   <= fix_y ? CELL_BITS'(b_qy_ff + 1'b1) : b_qy_ff[CELL_BITS-1:0];
         c_im_ff   <= fix_x ? 8'(rx - {1'b0, scale_ff}) : rx[7:0];
         c_jm_ff   <= fix_y ? 8'(ry - {1'b0, scale_ff}) : ry[7:0];
      end
   end

   // grid banks split by cell parity: bank index is {x parity, y parity}
   logic signed [VALUE_BITS-1:0] bank_rd [4];
   logic [CELL_BITS-1:0] ci_m1, cj_m1;
   assign ci_m1 = c_ci_ff - 1'b1;
   assign cj_m1 = c_cj_ff - 1'b1;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic signed [VALUE_BITS-1:0] mem [BANK_DEPTH];
      logic signed [VALUE_BITS-1:0] rd_ff;
      logic [CELL_BITS-1:0]         rx_sel, ry_sel;
      logic [BANK_AW-1:0]           raddr, waddr;
      logic                         we;
      logic [VALUE_BITS-1:0]        wdata;

      assign rx_sel = (c_ci_ff[0] == b[1]) ? c_ci_ff : ci_m1;
      assign ry_sel = (c_cj_ff[0] == b[0]) ? c_cj_ff : cj_m1;
      assign raddr  = {rx_sel[CELL_BITS-1:1], ry_sel[CELL_BITS-1:1]};
      assign we     = clr_busy_ff || (en && c_v_ff && !c_q_ff
                      && c_cx_ff[0] == b[1] && c_cy_ff[0] == b[0]);
      assign waddr  = clr_busy_ff ? clr_cnt_ff
                      : {c_cx_ff[CELL_BITS-1:1], c_cy_ff[CELL_BITS-1:1]};
      assign wdata  = clr_busy_ff ? '0 : c_val_ff;

      always_ff @(posedge clock) begin
         if (we) mem[waddr] <= wdata;
         if (en) rd_ff <= mem[raddr];
      end
      assign bank_rd[b] = rd_ff;
   end

   // stage D: bank reads and linear weights
   logic        d_v_ff;
   meta_type    d_meta_ff;
   logic        d_ci0_ff, d_cj0_ff;
   logic [15:0] d_a_ff [4];
   // stage E: values and squared weights
   logic                         e_v_ff;
   meta_type                     e_meta_ff;
   logic signed [VALUE_BITS-1:0] e_val_ff [4];
   logic [31:0]                  e_w_ff [4];
   // stage F: weighted terms
   logic               f_v_ff;
   meta_type           f_meta_ff;
   logic signed [48:0] f_p_ff [4];
   logic [33:0]        f_wsum_ff;
   // stage G: sum and limit
   logic               g_v_ff;
   meta_type           g_meta_ff;
   logic signed [50:0] g_sum_ff;
   logic [LIM_BITS-1:0] g_lim_ff;
   // stage H: classify and scale by 255
   logic                h_v_ff;
   meta_type            h_meta_ff;
   logic [NUM_BITS-1:0] h_num_ff;
   logic [LIM_BITS-1:0] h_lim_ff;

   logic [7:0] sjm, sim;
   logic [1:0] bsel [4];
   logic [LIM_BITS-1:0] g_sum48;

   assign sjm = scale_ff - c_jm_ff;
   assign sim = scale_ff - c_im_ff;
   assign bsel[0] = {d_ci0_ff, d_cj0_ff};
   assign bsel[1] = {d_ci0_ff, ~d_cj0_ff};
   assign bsel[2] = {~d_ci0_ff, d_cj0_ff};
   assign bsel[3] = {~d_ci0_ff, ~d_cj0_ff};
   assign g_sum48 = g_sum_ff[LIM_BITS-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         d_meta_ff <= c_meta_ff;
         d_ci0_ff  <= c_ci_ff[0];
         d_cj0_ff  <= c_cj_ff[0];
         d_a_ff[0] <= c_jm_ff * c_im_ff;
         d_a_ff[1] <= sjm * c_im_ff;
         d_a_ff[2] <= sim * c_jm_ff;
         d_a_ff[3] <= sjm * sim;

         e_meta_ff <= d_meta_ff;
         for (int k = 0; k < 4; k++) begin
            e_val_ff[k] <= bank_rd[bsel[k]];
            e_w_ff[k]   <= d_a_ff[k] * d_a_ff[k];
         end

         f_meta_ff <= e_meta_ff;
         for (int k = 0; k < 4; k++) begin
            f_p_ff[k] <= e_val_ff[k] * $signed({1'b0, e_w_ff[k]});
         end
         f_wsum_ff <= 34'(e_w_ff[0]) + 34'(e_w_ff[1]) + 34'(e_w_ff[2])
                      + 34'(e_w_ff[3]);

         g_meta_ff <= f_meta_ff;
         g_sum_ff  <= 51'(f_p_ff[0]) + 51'(f_p_ff[1]) + 51'(f_p_ff[2])
                      + 51'(f_p_ff[3]);
         g_lim_ff  <= {f_wsum_ff, {FRAC_BITS{1'b0}}};

         h_meta_ff <= '{px: g_meta_ff.px, py: g_meta_ff.py, ok: g_meta_ff.ok,
                        neg: (g_sum_ff <= 51'sd0),
                        sat: (g_sum_ff >= $signed({3'd0, g_lim_ff}))};
         h_num_ff  <= {g_sum48, 8'd0} - NUM_BITS'(g_sum48);
         h_lim_ff  <= g_lim_ff;
      end
   end

   // restoring divider, one quotient bit per stage
   logic                dv_v_ff    [DIV_STAGES];
   meta_type            dv_meta_ff [DIV_STAGES];
   logic [NUM_BITS-1:0] dv_rem_ff  [DIV_STAGES];
   logic [LIM_BITS-1:0] dv_lim_ff  [DIV_STAGES];
   logic [7:0]          dv_q_ff    [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      localparam int SH = DIV_STAGES - 1 - j;
      logic [NUM_BITS-1:0] rem_i, dsub;
      logic [LIM_BITS-1:0] lim_i;
      logic [7:0]          q_i;
      logic                take;
      meta_type            meta_i;
      if (j == 0) begin : g_first
         assign rem_i  = h_num_ff;
         assign lim_i  = h_lim_ff;
         assign q_i    = '0;
         assign meta_i = h_meta_ff;
      end else begin : g_next
         assign rem_i  = dv_rem_ff[j-1];
         assign lim_i  = dv_lim_ff[j-1];
         assign q_i    = dv_q_ff[j-1];
         assign meta_i = dv_meta_ff[j-1];
      end
      assign dsub = NUM_BITS'(lim_i) << SH;
      assign take = rem_i >= dsub;
      always_ff @(posedge clock) begin
         if (en) begin
            dv_meta_ff[j] <= meta_i;
            dv_lim_ff[j]  <= lim_i;
            dv_rem_ff[j]  <= take ? rem_i - dsub : rem_i;
            dv_q_ff[j]    <= q_i | (take ? 8'(1 << SH) : 8'd0);
         end
      end
   end

   // valid bits of the whole pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
         for (int k = 0; k < DIV_STAGES; k++) dv_v_ff[k] <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_take;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff && c_q_ff;   // drop writes here
         e_v_ff <= d_v_ff;
         f_v_ff <= e_v_ff;
         g_v_ff <= f_v_ff;
         h_v_ff <= g_v_ff;
         dv_v_ff[0] <= h_v_ff;
         for (int k = 1; k < DIV_STAGES; k++) dv_v_ff[k] <= dv_v_ff[k-1];
      end
   end

   // result select, output register and skid
   meta_type   fin_meta;
   logic [7:0] fin_gray;
   logic [36:0] fin_in;
   logic        fin_v;
   logic        out_v_ff;
   logic [36:0] out_ff, skid_ff;
   logic        out_take;

   assign fin_v    = dv_v_ff[DIV_STAGES-1];
   assign fin_meta = dv_meta_ff[DIV_STAGES-1];
   assign fin_gray = !fin_meta.ok ? 8'd0 : fin_meta.neg ? 8'd0
                     : fin_meta.sat ? 8'd255 : dv_q_ff[DIV_STAGES-1];
   assign fin_in   = {fin_meta.ok, fin_gray, fin_meta.py, fin_meta.px};
   assign out_take = out_v_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (out_take) skid_v_ff <= 1'b0;
      end else if (fin_v) begin
         if (out_v_ff && !out_take) skid_v_ff <= 1'b1;
         else out_v_ff <= 1'b1;
      end else if (out_take) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (out_take) out_ff <= skid_ff;
      end else if (fin_v) begin
         if (out_v_ff && !out_take) skid_ff <= fin_in;
         else out_ff <= fin_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'd0, out_ff[35:0]};
   assign rsp_tuser  = out_ff[36];

endmodule

### src/guwg_checker.sv
// Port-level checks of the weighted gray grid upscaler.
module guwg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // hold a result until transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before transfer");

   a_out_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[35:28] == 8'd0)
      else $error("out of range pixel with nonzero gray");

   a_clear: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input taken during grid clearing");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:36] == 4'd0)
      else $error("fill bits of result nonzero");

endmodule

bind grid_upscale_weighted_gray guwg_checker u_guwg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### test/grid_upscale_weighted_gray_tb.sv
// Self-checking testbench for the weighted gray grid upscaler.
`timescale 1ns / 1ps

module grid_upscale_weighted_gray_tb;
   import guwg_pkg::*;

   localparam int  LIMIT_CYCLES = 400000;
   localparam int  DRAIN_CYCLES = 40;
   localparam int  PHASES       = 10;

   typedef struct packed {
      logic [PIX_BITS-1:0] x;
      logic [PIX_BITS-1:0] y;
      logic [7:0]          gray;
      logic                in_range;
   } pixel_type;

   typedef struct {
      logic                   cmd;
      logic [5:0]             cx;
      logic [5:0]             cy;
      logic signed [15:0]     val;
      logic [PIX_BITS-1:0]    px;
      logic [PIX_BITS-1:0]    py;
      bit                     typed;
      logic [7:0]             gray;
      logic                   in_range;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [55:0] req_tdata = '0;   // cell_x, cell_y, cell_value, pixel_x, pixel_y
   logic [0:0] req_tuser = '0;    // cmd
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // out_x, out_y, gray, zero fill
   logic [0:0] rsp_tuser;         // in_range
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   grid_upscale_weighted_gray dut (.*);

   always #6 clock = ~clock;

   // predictor state
   logic signed [15:0] grid_copy [GRID_MAX][GRID_MAX];
   logic [6:0] size_copy = GRID_SIZE_RESET;
   logic [7:0] scale_copy = SCALE_RESET;
   pixel_type pending_pixels [$];
   int errors = 0;
   int checked = 0;
   int cycles = 0;
   int queries = 0;
   int writes = 0;
   bit quiet = 0;

   function automatic pixel_type gray_of(input logic [PIX_BITS-1:0] px, py);
      pixel_type r;
      longint n, s, ci, cj, im, jm, w1, w2, w3, w4, w, sum, lim;
      r.x = px;
      r.y = py;
      r.gray = '0;
      n = (size_copy > GRID_MAX) ? GRID_MAX : size_copy;
      s = scale_copy;
      r.in_range = s != 0 && px >= s && py >= s && px < n * s && py < n * s;
      if (r.in_range) begin
         ci = px / s; im = px % s;
         cj = py / s; jm = py % s;
         w1 = (jm * im) * (jm * im);
         w2 = ((s - jm) * im) * ((s - jm) * im);
         w3 = ((s - im) * jm) * ((s - im) * jm);
         w4 = ((s - jm) * (s - im)) * ((s - jm) * (s - im));
         w = w1 + w2 + w3 + w4;
         sum = longint'(grid_copy[ci][cj]) * w1 + longint'(grid_copy[ci][cj-1]) * w2
             + longint'(grid_copy[ci-1][cj]) * w3 + longint'(grid_copy[ci-1][cj-1]) * w4;
         lim = w << FRAC_BITS;
         if (sum <= 0) r.gray = 8'd0;
         else if (sum >= lim) r.gray = 8'd255;
         else r.gray = 8'((sum * 255) / lim);
      end
      return r;
   endfunction

   task automatic send_item(input row_type it);
      pixel_type p;
      while (!quiet && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.cmd;
      req_tdata <= {it.py, it.px, it.val, it.cy, it.cx};
      do @(posedge clock); while (!req_tready);
      if (it.cmd == CMD_WRITE) begin
         grid_copy[it.cx][it.cy] = it.val;
         writes++;
      end else begin
         p = gray_of(it.px, it.py);
         if (it.typed && (p.gray != it.gray || p.in_range != it.in_range))
            $display("note: typed expectation differs from predictor at (%0d,%0d)",
                     it.px, it.py);
         if (it.typed) begin
            p.gray = it.gray;
            p.in_range = it.in_range;
         end
         pending_pixels.push_back(p);
         queries++;
      end
      @(negedge clock);
   endtask

   task automatic idle_drain();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic addr_sel, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {addr_sel, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr_sel == REG_GRID_SIZE) size_copy = value[6:0];
      else scale_copy = value[7:0];
   endtask

   function automatic row_type random_item();
      row_type it;
      int span;
      int n;
      it.typed = 0;
      it.cx = 6'($urandom);
      it.cy = 6'($urandom);
      it.val = 16'($urandom);
      it.px = PIX_BITS'($urandom);
      it.py = PIX_BITS'($urandom);
      it.cmd = ($urandom_range(99) < 35) ? CMD_WRITE : CMD_QUERY;
      if (it.cmd == CMD_WRITE) begin
         case ($urandom_range(9))
            0: it.val = 16'sh7fff;
            1: it.val = 16'sh8000;
            2: it.val = 16'sh4000;
            default: ;
         endcase
      end else if ($urandom_range(99) < 85) begin
         n = (size_copy > GRID_MAX) ? GRID_MAX : size_copy;
         span = n * scale_copy + scale_copy + 1;
         if (span > 16384) span = 16384;
         it.px = PIX_BITS'($urandom_range(span - 1));
         it.py = PIX_BITS'($urandom_range(span - 1));
      end
      return it;
   endfunction

   // result side
   always @(negedge clock)
      rsp_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 37);

   always @(posedge clock) begin
      pixel_type want;
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transfer %h", rsp_tdata);
         end else begin
            want = pending_pixels.pop_front();
            checked++;
            if (rsp_tdata[13:0] != want.x || rsp_tdata[27:14] != want.y ||
                rsp_tdata[35:28] != want.gray || rsp_tuser[0] != want.in_range) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: want x=%0d y=%0d gray=%0d ok=%0d, got x=%0d y=%0d gray=%0d ok=%0d",
                           want.x, want.y, want.gray, want.in_range, rsp_tdata[13:0],
                           rsp_tdata[27:14], rsp_tdata[35:28], rsp_tuser[0]);
            end
         end
      end
   end

   row_type directed [20];
   int grid_sizes [PHASES] = '{64, 2, 127, 0, 1, 8, 64, 17, 33, 5};
   int scales [PHASES]     = '{1, 255, 3, 5, 7, 0, 255, 4, 128, 13};

   initial begin
      for (int i = 0; i < GRID_MAX; i++)
         for (int j = 0; j < GRID_MAX; j++) grid_copy[i][j] = '0;
      directed = '{
         '{CMD_QUERY, 0, 0, 0, 10, 10, 1, 8'd0, 1'b1},
         '{CMD_QUERY, 0, 0, 0, 9, 10, 1, 8'd0, 1'b0},
         '{CMD_QUERY, 0, 0, 0, 10, 400, 1, 8'd0, 1'b0},
         '{CMD_QUERY, 0, 0, 0, 399, 399, 1, 8'd0, 1'b1},
         '{CMD_QUERY, 0, 0, 0, 14'h3fff, 14'h3fff, 1, 8'd0, 1'b0},
         '{CMD_QUERY, 0, 0, 0, 0, 0, 1, 8'd0, 1'b0},
         '{CMD_WRITE, 0, 0, 16'sh7fff, 0, 0, 0, 0, 0},
         '{CMD_WRITE, 63, 63, 16'sh8000, 14'h3fff, 14'h3fff, 0, 0, 0},
         '{CMD_QUERY, 0, 0, 0, 10, 10, 0, 0, 0},
         '{CMD_QUERY, 0, 0, 0, 15, 15, 0, 0, 0},
         '{CMD_WRITE, 1, 1, 16'sh7fff, 0, 0, 0, 0, 0},
         '{CMD_QUERY, 0, 0, 0, 20, 20, 1, 8'd255, 1'b1},
         '{CMD_WRITE, 1, 1, -16'sd1, 0, 0, 0, 0, 0},
         '{CMD_QUERY, 0, 0, 0, 20, 20, 1, 8'd0, 1'b1},
         '{CMD_WRITE, 1, 1, 16'sh2000, 0, 0, 0, 0, 0},
         '{CMD_QUERY, 0, 0, 0, 20, 20, 1, 8'd127, 1'b1},
         '{CMD_QUERY, 0, 0, 0, 15, 17, 0, 0, 0},
         '{CMD_WRITE, 2, 1, 16'sh4000, 0, 0, 0, 0, 0},
         '{CMD_QUERY, 0, 0, 0, 25, 14, 0, 0, 0},
         '{CMD_QUERY, 0, 0, 0, 36, 14, 0, 0, 0}
      };
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      // hold off until the grid clear after reset is done
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      foreach (directed[k]) send_item(directed[k]);
      for (int ph = 0; ph < PHASES; ph++) begin
         idle_drain();
         csr_write(REG_GRID_SIZE, grid_sizes[ph]);
         csr_write(REG_SCALE, scales[ph]);
         for (int k = 0; k < 153; k++) begin
            quiet = (ph == 6);
            send_item(random_item());
         end
         quiet = 0;
      end
      idle_drain();
      $display("covered %0d grid writes and %0d pixel queries over %0d register settings",
               writes, queries, PHASES + 1);
      $display("%0d results compared, %0d errors", checked, errors);
      if (errors == 0 && pending_pixels.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### filelist.f
src/guwg_pkg.sv
src/grid_upscale_weighted_gray.sv
src/guwg_checker.sv
test/grid_upscale_weighted_gray_tb.sv
